// ===== hw/rtl/emta_pkg.sv =====
// ----------------------------------------------------------------------------
// emta_pkg: shared types and constants for the ellipse moments to axes unit
// Request type passed from the front end to the back end, status codes,
// fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package emta_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [15:0] RATIO_RESET = 16'd2560;
  localparam logic [23:0] AXIS_MAX    = 24'hFF_FFFF;

  // CORDIC datapath: magnitudes are normalized into [2^40, 2^41)
  localparam int CORDIC_W = 45;
  localparam int NORM_TOP = 41;
  // angle accumulator, pi = 2^31
  localparam int ANGLE_W = 34;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN = 34'sh0_8000_0000;

  localparam logic [1:0] STATUS_NORMAL  = 2'd0;
  localparam logic [1:0] STATUS_CLAMP   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // classified request handed from front end to back end
  typedef struct packed {
    logic               neg;
    logic [31:0]        g1;
    logic [30:0]        ag2;
    logic [31:0]        ac;
    logic signed [31:0] g2;
    logic signed [31:0] c;
  } req_t;

  // atan(2^-i) in units of pi = 2^31
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/emta_front.sv =====
// ----------------------------------------------------------------------------
// emta_front: input register and classification
// Accepts one moment set per cycle while the queue takes requests, flags negative
// Mxx or Myy and forms g1, g2, |g2| and |Mxy| for the back end.
// ----------------------------------------------------------------------------
module emta_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] moment_xx,
  input  logic signed [31:0] moment_yy,
  input  logic signed [31:0] moment_xy,
  output logic               req_valid,
  input  logic               req_ready,
  output emta_pkg::req_t     req
);

  logic               held;
  emta_pkg::req_t     cls;
  logic signed [31:0] g2;
  logic [31:0]        g2_abs;

  // classify the incoming moments
  always_comb begin
    g2          = moment_xx - moment_yy;
    g2_abs      = g2[31] ? 32'(-g2) : 32'(g2);
    cls.neg     = moment_xx[31] | moment_yy[31];
    cls.g1      = {1'b0, moment_xx[30:0]} + {1'b0, moment_yy[30:0]};
    cls.g2      = g2;
    cls.ag2     = g2_abs[30:0];
    cls.ac      = moment_xy[31] ? 32'(-moment_xy) : 32'(moment_xy);
    cls.c       = moment_xy;
  end

  // take a request whenever the register is empty or draining
  assign in_ready  = !held || req_ready;
  assign req_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= cls;
    end
  end

endmodule

// ===== hw/rtl/emta_queue.sv =====
// ----------------------------------------------------------------------------
// emta_queue: short request queue
// Decouples the front end from the back end so each side stalls alone.
// ----------------------------------------------------------------------------
module emta_queue #(
  parameter int DEPTH = emta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  emta_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output emta_pkg::req_t pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  emta_pkg::req_t mem [0:DEPTH-1];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = count != NW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // store a request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/emta_sqrt.sv =====
// ----------------------------------------------------------------------------
// emta_sqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence; gives floor root and
// remainder. Side data travels with each stage.
// ----------------------------------------------------------------------------
module emta_sqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic [IN_W/2-1:0] root,
  output logic [IN_W/2:0]   rem,
  output logic [SIDE_W-1:0] side_out
);

  localparam int N  = IN_W / 2;
  localparam int RW = N + 2;

  logic [RW-1:0]     st_rem  [0:N];
  logic [N-1:0]      st_root [0:N];
  logic [IN_W-1:0]   st_rad  [0:N];
  logic [SIDE_W-1:0] st_side [0:N];

  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_rad[0]  = rad;
  assign st_side[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // bring down two bits and try the next root bit
    always_comb begin
      rem_sh = {st_rem[k][RW-3:0], st_rad[k][IN_W-1 -: 2]};
      trial  = {st_root[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        st_root[k+1] <= {st_root[k][N-2:0], ge};
        st_rad[k+1]  <= st_rad[k] << 2;
        st_side[k+1] <= st_side[k];
      end
    end
  end

  assign root     = st_root[N];
  assign rem      = st_rem[N][N:0];
  assign side_out = st_side[N];

endmodule

// ===== hw/rtl/emta_div.sv =====
// ----------------------------------------------------------------------------
// emta_div: pipelined unsigned divider
// One quotient bit per stage, restoring. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module emta_div #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W:0]    st_rem  [0:NUM_W];
  logic [NUM_W-1:0]  st_quo  [0:NUM_W];
  logic [NUM_W-1:0]  st_num  [0:NUM_W];
  logic [DEN_W-1:0]  st_den  [0:NUM_W];
  logic [SIDE_W-1:0] st_side [0:NUM_W];

  assign st_rem[0]  = '0;
  assign st_quo[0]  = '0;
  assign st_num[0]  = num;
  assign st_den[0]  = den;
  assign st_side[0] = side_in;

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] rem_sh;
    logic           ge;

    // shift in the next numerator bit and try a subtract
    always_comb begin
      rem_sh = {st_rem[k][DEN_W-1:0], st_num[k][NUM_W-1]};
      ge     = rem_sh >= {1'b0, st_den[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? rem_sh - {1'b0, st_den[k]} : rem_sh;
        st_quo[k+1]  <= {st_quo[k][NUM_W-2:0], ge};
        st_num[k+1]  <= st_num[k] << 1;
        st_den[k+1]  <= st_den[k];
        st_side[k+1] <= st_side[k];
      end
    end
  end

  assign quo      = st_quo[NUM_W];
  assign side_out = st_side[NUM_W];

endmodule

// ===== hw/rtl/emta_cordic.sv =====
// ----------------------------------------------------------------------------
// emta_cordic: pipelined vectoring CORDIC for atan2(y, x) / 2
// Half-plane fold, six-stage normalizing shifter, one CORDIC step per
// stage, then rounding to the 16-bit orientation (32768 = pi/2).
// ----------------------------------------------------------------------------
module emta_cordic #(
  parameter int STEPS  = emta_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x_in,
  input  logic signed [32:0] y_in,
  input  logic [SIDE_W-1:0]  side_in,
  output logic [15:0]        angle,
  output logic [SIDE_W-1:0]  side_out
);

  localparam int CW = emta_pkg::CORDIC_W;
  localparam int MW = emta_pkg::NORM_TOP + 1;
  localparam int ZW = emta_pkg::ANGLE_W;
  localparam int NS = 6;
  localparam int L  = NS + STEPS;

  logic signed [CW-1:0] sx    [0:L];
  logic signed [CW-1:0] sy    [0:L];
  logic signed [ZW-1:0] sz    [0:L];
  logic                 szero [0:L];
  logic [SIDE_W-1:0]    sside [0:L];
  logic [MW-1:0]        sm    [0:NS];

  logic signed [CW-1:0] xe, ye, x0, y0, ay0;
  logic [MW-1:0]        m0;
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] zr;

  // fold the left half plane onto the right one
  always_comb begin
    xe  = CW'(x_in);
    ye  = CW'(y_in);
    x0  = x_in[31] ? -xe : xe;
    y0  = x_in[31] ? -ye : ye;
    ay0 = y0[CW-1] ? -y0 : y0;
    m0  = (x0 > ay0) ? MW'(x0) : MW'(ay0);
    z0  = x_in[31] ? (y_in[32] ? -emta_pkg::HALF_TURN : emta_pkg::HALF_TURN) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]    <= x0;
      sy[0]    <= y0;
      sz[0]    <= z0;
      sm[0]    <= m0;
      szero[0] <= (x_in == '0) && (y_in == '0);
      sside[0] <= side_in;
    end
  end

  // normalize: shift by 32, 16, ... 1 while the magnitude stays below 2^41
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int S = 32 >> j;
    logic up;
    assign up = (sm[j] >> (emta_pkg::NORM_TOP - S)) == '0;

    always_ff @(posedge clk) begin
      if (en) begin
        sx[j+1]    <= up ? sx[j] <<< S : sx[j];
        sy[j+1]    <= up ? sy[j] <<< S : sy[j];
        sm[j+1]    <= up ? sm[j] << S : sm[j];
        sz[j+1]    <= sz[j];
        szero[j+1] <= szero[j];
        sside[j+1] <= sside[j];
      end
    end
  end

  // rotation steps toward the x axis
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam int P = NS + i;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    logic                 yneg;

    always_comb begin
      dx   = sy[P] >>> i;
      dy   = sx[P] >>> i;
      da   = ZW'(emta_pkg::atan_lut(5'(i)));
      yneg = sy[P][CW-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx[P+1]    <= yneg ? sx[P] - dx : sx[P] + dx;
        sy[P+1]    <= yneg ? sy[P] + dy : sy[P] - dy;
        sz[P+1]    <= yneg ? sz[P] - da : sz[P] + da;
        szero[P+1] <= szero[P];
        sside[P+1] <= sside[P];
      end
    end
  end

  // round half up and drop to pi/2 = 32768
  assign zr = sz[L] + ZW'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      angle    <= szero[L] ? '0 : zr[31:16];
      side_out <= sside[L];
    end
  end

endmodule

// ===== hw/rtl/emta_back.sv =====
// ----------------------------------------------------------------------------
// emta_back: axis and orientation pipeline
// Orientation CORDIC, g3 square root, axis square roots, ratio clamp test
// and clamp divider, all advancing together under one stall enable.
// ----------------------------------------------------------------------------
module emta_back #(
  parameter int CORDIC_STEPS = emta_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    ratio,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  emta_pkg::req_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [23:0]    major_axis,
  output logic [23:0]    minor_axis,
  output logic [15:0]    orientation,
  output logic [1:0]     status
);

  localparam int LAT = CORDIC_STEPS + 104;

  typedef struct packed {
    logic        neg;
    logic [31:0] g1;
    logic [30:0] ag2;
    logic [31:0] ac;
  } cside_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] g1;
    logic        odd;
    logic [15:0] ori;
  } rside_t;

  typedef struct packed {
    logic        clamp;
    logic [15:0] ori;
  } mside_t;

  typedef struct packed {
    logic        neg;
    logic        clamp;
    logic [15:0] ori;
    logic [24:0] maj;
    logic [24:0] mnr;
  } dside_t;

  logic           en;
  logic           take;
  logic [LAT-1:0] vld;
  logic [31:0]    r2;

  // advance the whole pipeline when the output slot frees up
  assign en        = !vld[LAT-1] || out_ready;
  assign pop_ready = en;
  assign take      = pop_valid && en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], take};
    end
  end

  // ratio squared for the clamp test
  always_ff @(posedge clk) begin
    r2 <= 32'(ratio) * 32'(ratio);
  end

  // orientation
  cside_t      c_in, c_out;
  logic [15:0] c_ang;

  assign c_in = '{neg: pop_data.neg, g1: pop_data.g1, ag2: pop_data.ag2, ac: pop_data.ac};

  emta_cordic #(
    .STEPS (CORDIC_STEPS),
    .SIDE_W($bits(cside_t))
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .x_in    (pop_data.g2),
    .y_in    ({pop_data.c, 1'b0}),
    .side_in (c_in),
    .angle   (c_ang),
    .side_out(c_out)
  );

  // square terms
  logic [61:0] s1_p1;
  logic [63:0] s1_p2;
  rside_t      s1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p1   <= 62'(c_out.ag2) * 62'(c_out.ag2);
      s1_p2   <= 64'(c_out.ac) * 64'(c_out.ac);
      s1_side <= '{neg: c_out.neg, g1: c_out.g1, odd: c_out.ag2[0], ori: c_ang};
    end
  end

  // t = floor(g2^2 / 4) + Mxy^2
  logic [63:0] s2_t;
  rside_t      s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t    <= {1'b0, 63'(s1_p1 >> 2) + 63'(s1_p2)};
      s2_side <= s1_side;
    end
  end

  logic [31:0] h;
  logic [32:0] h_rem;
  rside_t      h_side;

  emta_sqrt #(
    .IN_W  (64),
    .SIDE_W($bits(rside_t))
  ) u_sqrt_g3 (
    .clk     (clk),
    .en      (en),
    .rad     (s2_t),
    .side_in (s2_side),
    .root    (h),
    .rem     (h_rem),
    .side_out(h_side)
  );

  // g3 = 2h plus one when the odd term reaches past h^2 + h
  logic        inc;
  logic [32:0] g3;
  logic [33:0] s4_sum;
  logic [31:0] s4_diff;
  logic        s4_gt;
  logic        s4_neg;
  logic [15:0] s4_ori;

  always_comb begin
    inc = h_side.odd ? (h_rem >= 33'(h)) : (h_rem > 33'(h));
    g3  = {h, 1'b0} + 33'(inc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum  <= 34'(h_side.g1) + 34'(g3);
      s4_diff <= h_side.g1 - g3[31:0];
      s4_gt   <= 33'(h_side.g1) < g3;
      s4_neg  <= h_side.neg;
      s4_ori  <= h_side.ori;
    end
  end

  // (g1 - g3) * R^2
  logic [63:0] s5_prod;
  logic [33:0] s5_sum;
  logic [31:0] s5_diff;
  logic        s5_gt;
  logic        s5_neg;
  logic [15:0] s5_ori;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_prod <= 64'(s4_diff) * 64'(r2);
      s5_sum  <= s4_sum;
      s5_diff <= s4_diff;
      s5_gt   <= s4_gt;
      s5_neg  <= s4_neg;
      s5_ori  <= s4_ori;
    end
  end

  // clamp decision and square root radicands
  logic [49:0] s6_rad_maj;
  logic [49:0] s6_rad_min;
  mside_t      s6_mside;
  logic        s6_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rad_maj <= {1'b0, s5_sum, 15'b0};
      s6_rad_min <= {3'b0, s5_diff, 15'b0};
      s6_mside   <= '{clamp: s5_gt || (s5_prod < {14'b0, s5_sum, 16'b0}), ori: s5_ori};
      s6_neg     <= s5_neg;
    end
  end

  logic [24:0] maj;
  logic [24:0] mnr;
  mside_t      maj_side;
  logic        mnr_neg;

  emta_sqrt #(
    .IN_W  (50),
    .SIDE_W($bits(mside_t))
  ) u_sqrt_major (
    .clk     (clk),
    .en      (en),
    .rad     (s6_rad_maj),
    .side_in (s6_mside),
    .root    (maj),
    .rem     (),
    .side_out(maj_side)
  );

  emta_sqrt #(
    .IN_W  (50),
    .SIDE_W(1)
  ) u_sqrt_minor (
    .clk     (clk),
    .en      (en),
    .rad     (s6_rad_min),
    .side_in (s6_neg),
    .root    (mnr),
    .rem     (),
    .side_out(mnr_neg)
  );

  // clamped minor = major * 256 / R
  dside_t      d_in, d_out;
  logic [32:0] quo;

  assign d_in = '{neg: mnr_neg, clamp: maj_side.clamp, ori: maj_side.ori, maj: maj, mnr: mnr};

  emta_div #(
    .NUM_W (33),
    .DEN_W (16),
    .SIDE_W($bits(dside_t))
  ) u_div (
    .clk     (clk),
    .en      (en),
    .num     ({maj, 8'b0}),
    .den     (ratio),
    .side_in (d_in),
    .quo     (quo),
    .side_out(d_out)
  );

  // saturate and select; negative moments zero the axes and orientation and flag invalid
  logic [23:0] maj_sat;
  logic [23:0] mnr_sat;
  logic [23:0] quo_sat;

  always_comb begin
    maj_sat = d_out.maj[24] ? emta_pkg::AXIS_MAX : d_out.maj[23:0];
    mnr_sat = d_out.mnr[24] ? emta_pkg::AXIS_MAX : d_out.mnr[23:0];
    quo_sat = (quo[32:24] != '0) ? emta_pkg::AXIS_MAX : quo[23:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_out.neg) begin
        major_axis  <= '0;
        minor_axis  <= '0;
        orientation <= '0;
        status      <= emta_pkg::STATUS_INVALID;
      end else begin
        major_axis  <= maj_sat;
        minor_axis  <= d_out.clamp ? quo_sat : mnr_sat;
        orientation <= d_out.ori;
        status      <= d_out.clamp ? emta_pkg::STATUS_CLAMP : emta_pkg::STATUS_NORMAL;
      end
    end
  end

endmodule

// ===== hw/rtl/ellipse_moments_to_axes_unit.sv =====
// ----------------------------------------------------------------------------
// ellipse_moments_to_axes_unit: second moments to ellipse axes and angle
// Turns (Mxx, Myy, Mxy) into 1-sigma major/minor axes (Q16.8) and the
// major axis orientation, with ratio clamp and invalid-moment status.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_valid / cfg_ready   cfg_data (max axis ratio Q8.8)
//   in        in         in_valid / in_ready     moment_xx, moment_yy, moment_xy
//   out       out        out_valid / out_ready   major_axis, minor_axis,
//                                                orientation, status
//
// One request per cycle sustained while out_ready stays high. The path runs
// through the input register, queue, CORDIC (CORDIC_STEPS + 8), 32-stage
// g3 root, 25-stage axis roots and the 33-stage clamp divider, which dominate.
// Reset clears the handshake state and loads the ratio register with 10.0.
// A stalled output freezes the back pipeline; the queue then fills and
// in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module ellipse_moments_to_axes_unit #(
  parameter int CORDIC_STEPS = emta_pkg::CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = emta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] moment_xx,
  input  logic signed [31:0] moment_yy,
  input  logic signed [31:0] moment_xy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        major_axis,
  output logic [23:0]        minor_axis,
  output logic signed [15:0] orientation,
  output logic [1:0]         status
);

  logic [15:0]    ratio;
  logic           f_valid, f_ready;
  emta_pkg::req_t f_req;
  logic           q_valid, q_ready;
  emta_pkg::req_t q_req;
  logic [15:0]    ori;

  // ratio register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= emta_pkg::RATIO_RESET;
    end else if (cfg_valid) begin
      ratio <= cfg_data;
    end
  end

  emta_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .moment_xx(moment_xx),
    .moment_yy(moment_yy),
    .moment_xy(moment_xy),
    .req_valid(f_valid),
    .req_ready(f_ready),
    .req      (f_req)
  );

  emta_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_req),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_req)
  );

  emta_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ratio      (ratio),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .major_axis (major_axis),
    .minor_axis (minor_axis),
    .orientation(ori),
    .status     (status)
  );

  assign orientation = $signed(ori);

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ellipse_moments_to_axes_unit
// Drives moment requests and ratio writes with random idle and stall gaps.
// A scoreboard predicts major/minor axes, orientation and status for every
// accepted request and compares results in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [23:0]        major;
    logic [23:0]        minor;
    logic signed [15:0] angle;
    logic [1:0]         stat;
  } axes_t;

  // atan(2^-i), pi = 2^31
  localparam longint ATAN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0};

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= r + bits) begin
        v = v - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    return r;
  endfunction

  // angle of (x, y) in units of pi = 2^31
  function automatic longint vector_angle(input longint y, input longint x);
    longint z, m, dx, dy, ay;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m < (64'sd1 <<< 40)) begin
      m = m * 2;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < emta_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic axes_t predict_axes(input logic signed [31:0] mxx, myy, mxy,
                                         input logic [15:0] ratio);
    axes_t e;
    longint a, b, c, g2, ang;
    logic [63:0] g1, ag2, ac, t, h, hh, g3, sum, maj, mnr, rr;
    bit clamp;
    a = mxx;
    b = myy;
    c = mxy;
    e = '0;
    if (a < 0 || b < 0) begin
      e.stat = emta_pkg::STATUS_INVALID;
      return e;
    end
    g1 = a + b;
    g2 = a - b;
    ag2 = (g2 < 0) ? -g2 : g2;
    ac = (c < 0) ? -c : c;
    t = ((ag2 * ag2) >> 2) + ac * ac;
    h = int_sqrt(t);
    hh = h * h + h;
    g3 = 2 * h;
    if (ag2[0] ? (hh <= t) : (hh < t)) g3 = g3 + 1;
    sum = g1 + g3;
    rr = 64'(ratio);
    e.stat = emta_pkg::STATUS_NORMAL;
    if (sum == 0) begin
      maj = 0;
      mnr = 0;
    end else begin
      maj = int_sqrt(sum << 15);
      if (g3 > g1) clamp = 1;
      else clamp = (g1 - g3) * (rr * rr) < (sum << 16);
      if (clamp) begin
        e.stat = emta_pkg::STATUS_CLAMP;
        mnr = (rr == 0) ? 64'(emta_pkg::AXIS_MAX) : (maj << 8) / rr;
      end else begin
        mnr = int_sqrt((g1 - g3) << 15);
      end
    end
    if (maj > 64'(emta_pkg::AXIS_MAX)) maj = 64'(emta_pkg::AXIS_MAX);
    if (mnr > 64'(emta_pkg::AXIS_MAX)) mnr = 64'(emta_pkg::AXIS_MAX);
    ang = vector_angle(2 * c, g2);
    ang = (ang + (64'sd1 <<< 15)) >>> 16;
    e.major = maj[23:0];
    e.minor = mnr[23:0];
    e.angle = ang[15:0];
    return e;
  endfunction

  // in-order store of predicted axes
  class axes_scoreboard;
    axes_t pending[$];
    int n_clamp, n_invalid;

    function void note_request(logic signed [31:0] mxx, myy, mxy, logic [15:0] ratio);
      axes_t e;
      e = predict_axes(mxx, myy, mxy, ratio);
      if (e.stat == emta_pkg::STATUS_CLAMP) n_clamp++;
      if (e.stat == emta_pkg::STATUS_INVALID) n_invalid++;
      pending.push_back(e);
    endfunction

    function bit check_result(axes_t got, output string msg);
      axes_t e;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result %p", got);
        return 0;
      end
      e = pending.pop_front();
      if (got !== e) begin
        msg = $sformatf("got major %0d minor %0d angle %0d status %0d, want %0d %0d %0d %0d",
                        got.major, got.minor, got.angle, got.stat,
                        e.major, e.minor, e.angle, e.stat);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [31:0] moment_xx, moment_yy, moment_xy;
  logic out_valid, out_ready;
  logic [23:0] major_axis, minor_axis;
  logic signed [15:0] orientation;
  logic [1:0] status;

  ellipse_moments_to_axes_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .moment_xx(moment_xx), .moment_yy(moment_yy), .moment_xy(moment_xy),
    .out_valid(out_valid), .out_ready(out_ready),
    .major_axis(major_axis), .minor_axis(minor_axis),
    .orientation(orientation), .status(status)
  );

  axes_scoreboard sb = new();
  logic [15:0] ratio_now;
  int errors, n_requests, n_results;
  bit no_idle;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  // note accepted requests and check results
  always @(posedge clk) begin
    string msg;
    if (!rst && in_valid && in_ready) begin
      sb.note_request(moment_xx, moment_yy, moment_xy, ratio_now);
      n_requests++;
    end
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (!sb.check_result({major_axis, minor_axis, orientation, status}, msg))
        report(msg);
    end
  end

  // random back-pressure on the result side
  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_ratio(input logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    ratio_now = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // send one request; called at a falling edge
  task automatic send_request(input logic signed [31:0] xx, yy, xy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    moment_xx = xx;
    moment_yy = yy;
    moment_xy = xy;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold until the pipeline has drained
  task automatic drain();
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (emta_pkg::CORDIC_STEPS_DEF + 120) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_moment(input bit nonneg);
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if (nonneg) v[31] = 0;
    else if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic random_requests(input int n);
    logic signed [31:0] xx, yy, xy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        xx = $urandom;
        yy = $urandom;
        xy = $urandom;
      end else begin
        xx = rand_moment(1);
        yy = ($urandom_range(0, 7) == 0) ? xx : rand_moment(1);
        case ($urandom_range(0, 3))
          0: xy = 0;
          1: xy = $urandom;
          default: xy = rand_moment(0);
        endcase
      end
      send_request(xx, yy, xy);
    end
  endtask

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  task automatic directed_requests();
    send_request(0, 0, 0);
    send_request(S_MAX, S_MAX, S_MAX);
    send_request(S_MAX, S_MAX, S_MIN);
    send_request(S_MAX, 0, 0);
    send_request(0, S_MAX, 0);
    send_request(-1, 100, 5);
    send_request(100, -1, 5);
    send_request(S_MIN, S_MIN, S_MIN);
    send_request(0, 0, 1);
    send_request(0, 0, -1);
    send_request(1, 0, 0);
    send_request(0, 5, 0);
    send_request(65536, 65536, 0);
    send_request(100, 100, -50);
    send_request(10, 10, S_MAX);
    send_request(32'sh0100_0000, 32'sh0001_0000, 32'sh0000_8000);
    send_request(32'sh0001_0000, 32'sh0100_0000, -32'sh0000_8000);
    send_request(3, 1, 1);
    send_request(S_MAX, 1, -1);
  endtask

  initial begin
    logic [15:0] ratios [6];
    ratios = '{emta_pkg::RATIO_RESET, 16'd0, 16'd256, 16'hFFFF, 16'd1, 16'd0};
    ratios[5] = $urandom_range(257, 65534);
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    in_valid = 0;
    moment_xx = 0;
    moment_yy = 0;
    moment_xy = 0;
    ratio_now = emta_pkg::RATIO_RESET;
    repeat (4) @(negedge clk);
    rst = 0;
    directed_requests();
    drain();
    for (int p = 0; p < 6; p++) begin
      write_ratio(ratios[p]);
      if (p == 0) directed_requests();
      no_idle = (p == 3);
      random_requests(80);
      no_idle = 0;
      drain();
    end
    $display("requests %0d, results %0d (clamped %0d, invalid %0d), six ratio settings",
             n_requests, n_results, sb.n_clamp, sb.n_invalid);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end
endmodule
